// ----- hdl/llq_pkg.sv -----
// ----------------------------------------------------------------------------
// llq_pkg
// Shared constants, quadrature tables, beat types and arithmetic helpers for
// the linear line element quadrature block.
// ----------------------------------------------------------------------------
package llq_pkg;

    localparam int unsigned MAX_ORDER_W = 3;
    localparam logic [2:0]  MAX_ORDER   = 3'd5;
    localparam logic [2:0]  ORDER_RESET = 3'd2;
    localparam int unsigned ROM_N       = 15;

    // pipeline layout
    localparam int unsigned DIV_STEPS = 32;
    localparam int unsigned DIV_FIRST = 4;
    localparam int unsigned POST_ST   = DIV_FIRST + DIV_STEPS;
    localparam int unsigned STAGES    = POST_ST + 2;
    localparam int unsigned LAST_ST   = STAGES - 1;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_OUTSIDE = 2'd1,
        ERR_ZERO    = 2'd2
    } err_t;

    // gauss-legendre points on [-1,1] (signed Q1.30) and weights (unsigned Q2.30)
    localparam logic signed [30:0] ROM_PT [ROM_N] = '{
        31'sd0,
        -31'sd619925131, 31'sd619925131,
        -31'sd831716840, 31'sd0, 31'sd831716840,
        -31'sd365051866, 31'sd365051866, -31'sd924638074, 31'sd924638074,
        31'sd0, -31'sd578177019, 31'sd578177019, -31'sd973003201, 31'sd973003201
    };
    localparam logic [31:0] ROM_WT [ROM_N] = '{
        32'd2147483648,
        32'd1073741824, 32'd1073741824,
        32'd596523236, 32'd954437177, 32'd596523236,
        32'd700235528, 32'd700235528, 32'd373506296, 32'd373506296,
        32'd610839793, 32'd513923621, 32'd513923621, 32'd254398306, 32'd254398306
    };
    localparam logic [3:0] ROM_START [6] = '{4'd0, 4'd0, 4'd1, 4'd3, 4'd6, 4'd10};

    // one restoring divider lane
    typedef struct packed {
        logic [34:0] rem;
        logic [33:0] dv;
        logic [31:0] nlo;
        logic [31:0] q;
    } div_t;

    typedef struct packed {
        logic               cmd;
        logic               last;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] p;
        logic        [3:0]  idx;
        logic signed [32:0] j;
        logic signed [32:0] s;
        logic signed [34:0] num;
        logic        [32:0] aj;
        logic        [33:0] an;
        logic               negj;
        logic               negq;
        logic               jz;
        logic signed [30:0] pt;
        logic        [31:0] wt;
        logic signed [63:0] prod_c;
        logic signed [65:0] prod_w;
        logic signed [34:0] cfull;
        logic signed [35:0] wfull;
        logic        [16:0] sh1;
        logic        [16:0] sh2;
        logic signed [34:0] diff;
        logic        [36:0] t11;
        err_t               err;
        div_t               ta;
        div_t               tb;
        logic signed [32:0] d;
        logic signed [31:0] xi;
        logic signed [31:0] o_coord;
        logic signed [31:0] o_weight;
        logic        [16:0] o_sh1;
        logic        [16:0] o_sh2;
        logic signed [31:0] o_d1;
        logic signed [31:0] o_d2;
        logic signed [31:0] o_jac;
    } beat_t;

    typedef struct packed {
        logic               cmd;
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] p;
    } item_t;

    function automatic div_t div_step(input div_t x);
        logic [34:0] r2;
        logic        ge;
        div_t        y;
        r2    = {x.rem[33:0], x.nlo[31]};
        ge    = (r2 >= {1'b0, x.dv});
        y     = x;
        y.rem = ge ? (r2 - {1'b0, x.dv}) : r2;
        y.q   = {x.q[30:0], ge};
        y.nlo = {x.nlo[30:0], 1'b0};
        return y;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -36'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

// ----- hdl/linear_line_element_quadrature.sv -----
// ----------------------------------------------------------------------------
// linear_line_element_quadrature
// Two-node linear line element in Q16.16: gauss-legendre point expansion and
// point evaluation with shapes, derivatives and jacobian.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one beat per element command. cmd 0 expands into one result
//   beat per quadrature point (quad_order, clamped to five; order zero gives
//   none), cmd 1 gives exactly one result beat. m_last marks the final beat of
//   an element.
//   cfg_* channel: writes quad_order (3 bits); always ready, write only while
//   no element is in flight.
//   Throughput: one result beat per cycle while m_ready is high. The issue
//   stage emits one point per cycle into the pipeline while stage 0 can load.
//   The 32-stage restoring dividers (one quotient bit per stage) compute
//   0.5/J and xi.
//   Reset (aresetn low, synchronous) empties the pipeline and sets quad_order
//   to 2. When m_ready is low the pipeline keeps filling its empty stages and
//   then holds; s_ready is low while the issue stage holds an element it cannot finish.
// ----------------------------------------------------------------------------
module linear_line_element_quadrature (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [31:0] s_node_first_x,
    input  logic signed [31:0] s_node_second_x,
    input  logic signed [31:0] s_point_x,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_coord,
    output logic signed [31:0] m_weight,
    output logic [16:0]        m_shape_first,
    output logic [16:0]        m_shape_second,
    output logic signed [31:0] m_deriv_first,
    output logic signed [31:0] m_deriv_second,
    output logic signed [31:0] m_jacobian,
    output logic [1:0]         m_error,
    output logic               m_last
);
    import llq_pkg::*;

    logic [2:0]  quad_order_reg;
    item_t       hold_reg;
    logic        hold_v_reg;
    logic [2:0]  k_reg;
    logic [2:0]  n_reg;
    logic [2:0]  n_in;
    logic        beat_last;
    logic        beat_fire;
    logic        s_fire;
    logic [3:0]  idx;

    beat_t       st_reg  [STAGES];
    beat_t       st_next [STAGES];
    logic        v_reg   [STAGES];
    logic        en      [STAGES];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quad_order_reg <= ORDER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            quad_order_reg <= cfg_data;
        end
    end

    // issue stage: holds one element and sends one point beat per cycle while stage 0 can load
    assign n_in      = (quad_order_reg > MAX_ORDER) ? MAX_ORDER : quad_order_reg;
    assign beat_last = hold_reg.cmd || (k_reg == (n_reg - 3'd1));
    assign beat_fire = hold_v_reg && en[0];
    assign s_ready   = !hold_v_reg || (en[0] && beat_last);
    assign s_fire    = s_valid && s_ready;
    assign idx       = ROM_START[n_reg] + {1'b0, k_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_v_reg <= 1'b0;
            k_reg      <= '0;
            n_reg      <= '0;
        end else if (s_fire) begin
            hold_v_reg <= s_cmd || (n_in != 3'd0);
            k_reg      <= '0;
            n_reg      <= n_in;
        end else if (beat_fire) begin
            if (beat_last) begin
                hold_v_reg <= 1'b0;
            end else begin
                k_reg <= k_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hold_reg.cmd <= s_cmd;
            hold_reg.x0  <= s_node_first_x;
            hold_reg.x1  <= s_node_second_x;
            hold_reg.p   <= s_point_x;
        end
    end

    // stall chain: a stage loads when empty or when the next one moves
    always_comb begin
        en[LAST_ST] = !v_reg[LAST_ST] || m_ready;
        for (int i = LAST_ST - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i + 1];
        end
    end

    always_comb begin
        beat_t              b;
        logic signed [33:0] sp1;
        logic signed [65:0] csum;
        logic signed [65:0] wsum;
        logic signed [32:0] tsh;
        logic        [33:0] naf;
        logic        [63:0] nbf;
        logic        [32:0] qaa;
        logic        [31:0] qb;
        logic signed [31:0] xr;
        logic signed [35:0] dx;
        b    = '0;
        sp1  = '0;
        csum = '0;
        wsum = '0;
        tsh  = '0;
        naf  = '0;
        nbf  = '0;
        qaa  = '0;
        qb   = '0;
        xr   = '0;
        dx   = '0;

        // stage 0: jacobian, node sum, table lookup
        b      = '0;
        b.cmd  = hold_reg.cmd;
        b.last = beat_last;
        b.x0   = hold_reg.x0;
        b.x1   = hold_reg.x1;
        b.p    = hold_reg.p;
        b.idx  = idx;
        b.j    = {hold_reg.x1[31], hold_reg.x1} - {hold_reg.x0[31], hold_reg.x0};
        b.s    = {hold_reg.x1[31], hold_reg.x1} + {hold_reg.x0[31], hold_reg.x0};
        b.pt   = ROM_PT[idx];
        b.wt   = ROM_WT[idx];
        b.err  = ERR_OK;
        st_next[0] = b;

        // stage 1: numerator, |J|, products with J
        b        = st_reg[0];
        b.num    = {{2{b.p[31]}}, b.p, 1'b0} - {{2{b.s[32]}}, b.s};
        b.negj   = b.j[32];
        b.jz     = (b.j == 33'sd0);
        b.aj     = b.j[32] ? 33'(-b.j) : 33'(b.j);
        b.prod_c = 64'(b.pt) * 64'(b.j);
        b.prod_w = $signed({34'd0, b.wt}) * 66'(b.j);
        st_next[1] = b;

        // stage 2: rounding of coord and weight, point shapes, 0.5/J divider setup
        b       = st_reg[1];
        b.an    = b.num[34] ? 34'(-b.num) : 34'(b.num);
        b.negq  = b.num[34] ^ b.negj;
        sp1     = {b.s[32], b.s} + 34'sd1;
        csum    = {{2{sp1[33]}}, sp1, 30'd0} + {{2{b.prod_c[63]}}, b.prod_c};
        b.cfull = csum[65:31];
        wsum    = b.prod_w + 66'sd536870912;
        b.wfull = wsum[65:30];
        tsh     = 33'sd1073758208 - {{2{b.pt[30]}}, b.pt};
        b.sh1   = tsh[31:15];
        tsh     = 33'sd1073758208 + {{2{b.pt[30]}}, b.pt};
        b.sh2   = tsh[31:15];
        naf     = {1'b0, b.aj} + 34'h1_0000_0000;
        b.ta.rem = {33'd0, naf[33:32]};
        b.ta.nlo = naf[31:0];
        b.ta.dv  = {b.aj, 1'b0};
        b.ta.q   = '0;
        st_next[2] = b;

        // stage 3: xi divider setup, outside test operands
        b        = st_reg[2];
        nbf      = {b.an, 30'd0} + {32'd0, b.aj[32:1]};
        b.tb.rem = {3'd0, nbf[63:32]};
        b.tb.nlo = nbf[31:0];
        b.tb.dv  = {1'b0, b.aj};
        b.tb.q   = '0;
        b.diff   = $signed({1'b0, b.an}) - $signed({2'b00, b.aj});
        b.t11    = {1'b0, b.aj, 3'd0} + {3'd0, b.aj, 1'b0} + {4'd0, b.aj};
        st_next[3] = b;

        // divider stages, one quotient bit each
        for (int i = DIV_FIRST; i < POST_ST; i++) begin
            b    = st_reg[i - 1];
            b.ta = div_step(b.ta);
            b.tb = div_step(b.tb);
            if (i == DIV_FIRST) begin
                if (b.jz) begin
                    b.err = ERR_ZERO;
                end else if (b.cmd && !b.diff[34] && (b.diff != 35'sd0) &&
                             ((b.diff[33:7] != 27'd0) || ({b.diff[6:0], 30'd0} > b.t11))) begin
                    b.err = ERR_OUTSIDE;
                end else begin
                    b.err = ERR_OK;
                end
            end
            st_next[i] = b;
        end

        // post stage 0: signed derivative and clamped xi
        b   = st_reg[POST_ST - 1];
        qaa = {1'b0, b.ta.q};
        if (b.jz) begin
            b.d = '0;
        end else begin
            b.d = b.negj ? -$signed(qaa) : $signed(qaa);
        end
        if (b.err == ERR_OUTSIDE || b.tb.q > 32'd1073741824) begin
            qb = 32'd1073741824;
        end else begin
            qb = b.tb.q;
        end
        b.xi = b.negq ? -$signed(qb) : $signed(qb);
        st_next[POST_ST] = b;

        // post stage 1: output formatting and saturation
        b  = st_reg[POST_ST];
        xr = (b.xi + 32'sd8192) >>> 14;
        dx = {{3{b.d[32]}}, b.d};
        if (b.cmd) begin
            b.o_weight = '0;
            if (b.jz) begin
                b.o_coord = '0;
                b.o_sh1   = '0;
                b.o_sh2   = '0;
            end else begin
                b.o_coord = xr;
                tsh       = 33'sd1073758208 - {b.xi[31], b.xi};
                b.o_sh1   = tsh[31:15];
                tsh       = 33'sd1073758208 + {b.xi[31], b.xi};
                b.o_sh2   = tsh[31:15];
            end
        end else begin
            b.o_coord  = sat32({b.cfull[34], b.cfull});
            b.o_weight = sat32(b.wfull);
            b.o_sh1    = b.sh1;
            b.o_sh2    = b.sh2;
        end
        b.o_d1  = sat32(-dx);
        b.o_d2  = sat32(dx);
        b.o_jac = sat32({{3{b.j[32]}}, b.j});
        st_next[LAST_ST] = b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else begin
            if (en[0]) begin
                v_reg[0] <= beat_fire;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (en[i]) begin
                    v_reg[i] <= v_reg[i - 1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < STAGES; i++) begin
            if (en[i]) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    assign m_valid        = v_reg[LAST_ST];
    assign m_coord        = st_reg[LAST_ST].o_coord;
    assign m_weight       = st_reg[LAST_ST].o_weight;
    assign m_shape_first  = st_reg[LAST_ST].o_sh1;
    assign m_shape_second = st_reg[LAST_ST].o_sh2;
    assign m_deriv_first  = st_reg[LAST_ST].o_d1;
    assign m_deriv_second = st_reg[LAST_ST].o_d2;
    assign m_jacobian     = st_reg[LAST_ST].o_jac;
    assign m_error        = st_reg[LAST_ST].err;
    assign m_last         = st_reg[LAST_ST].last;

    // issue stage always free when it holds nothing
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !hold_v_reg |-> s_ready)
        else $error("s_ready low with empty issue stage");

    // an order-zero quadrature command leaves nothing behind
    a_zero_order_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !s_cmd && n_in == 3'd0) |=> !hold_v_reg)
        else $error("order-zero element was issued");

    // zero-length element has no derivatives
    a_zero_len_deriv: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error == ERR_ZERO) |-> (m_deriv_first == 32'sd0 && m_deriv_second == 32'sd0))
        else $error("nonzero derivative on zero-length element");

    // outside points are clamped to an element end
    a_outside_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error == ERR_OUTSIDE) |->
            ((m_coord == 32'sd65536 && m_shape_first == 17'd0) ||
             (m_coord == -32'sd65536 && m_shape_second == 17'd0)))
        else $error("outside point not clamped");

    // a stalled output beat stays put until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_coord) && $stable(m_last)))
        else $error("output beat changed under stall");

endmodule
